### rtl/core/rdc_pkg.sv
// Shared constants and helpers for the radix digit converter.
// No dependencies; imported by every module of the block.
package rdc_pkg;

  localparam int unsigned VALUE_BITS_DEF = 31;
  localparam int unsigned RADIX_W        = 6;
  localparam int unsigned DIV_STEP       = 4;  // quotient bits resolved per cycle
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // Clamp a written radix into the supported range.
  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] raw);
    logic [RADIX_W-1:0] r;
    r = raw;
    if (r < RADIX_MIN) r = RADIX_MIN;
    if (r > RADIX_MAX) r = RADIX_MAX;
    return r;
  endfunction

endpackage

### rtl/core/rdc_front.sv
// Front end: takes input items, drops zero values and queues the rest.
// Depends on rdc_pkg for the queue depth and the default value width.
module rdc_front
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  q_valid_o,
  output logic [VALUE_BITS-1:0] q_value_o,
  input  logic                  q_take_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_BITS-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]      count_q;
  logic                  wr_en, rd_en;

  assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
  // A zero value yields no digits: drop it at the door.
  assign wr_en     = push && !full && (value_i != '0);
  assign q_valid_o = (count_q != '0);
  assign q_value_o = mem_q[rd_ptr_q];
  assign rd_en     = q_take_i && q_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= value_i;
    end
  end

endmodule

### rtl/core/rdc_back.sv
// Back end: repeated division into a digit stack, then digits out most
// significant first through a one-entry result register. Depends on rdc_pkg.
module rdc_back
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [RADIX_W-1:0]    radix_i,
  input  logic                  q_valid_i,
  input  logic [VALUE_BITS-1:0] q_value_i,
  output logic                  q_take_o,
  output logic                  empty,
  input  logic                  pop,
  output logic [RADIX_W-1:0]    digit_o,
  output logic                  last_o
);

  localparam int unsigned PAD_BITS = ((VALUE_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int unsigned STEPS    = PAD_BITS / DIV_STEP;
  localparam int unsigned STEP_W   = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned IDX_W    = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W    = $clog2(VALUE_BITS + 1);

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StEmit
  } state_e;

  state_e              state_q;
  logic [PAD_BITS-1:0] work_q;
  logic [RADIX_W-1:0]  rem_q;
  logic [RADIX_W-1:0]  radix_q;
  logic [STEP_W-1:0]   step_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                out_valid_q;
  logic [RADIX_W-1:0]  out_digit_q;
  logic                out_last_q;
  logic [RADIX_W-1:0]  stack_q [VALUE_BITS];

  logic [PAD_BITS-1:0] div_work;
  logic [RADIX_W-1:0]  div_rem;
  logic [RADIX_W:0]    trial;
  logic                digit_done;
  logic                load_out;
  logic [CNT_W-1:0]    cnt_dec;

  // Restoring division, DIV_STEP quotient bits per cycle, MSB first.
  always_comb begin
    div_work = work_q;
    div_rem  = rem_q;
    trial    = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial    = {div_rem, div_work[PAD_BITS-1]};
      div_work = {div_work[PAD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, radix_q}) begin
        trial       = trial - {1'b0, radix_q};
        div_work[0] = 1'b1;
      end
      div_rem = trial[RADIX_W-1:0];
    end
  end

  assign digit_done = (state_q == StDivide) && (step_q == STEP_W'(STEPS - 1));
  assign load_out   = (state_q == StEmit) && (!out_valid_q || pop);
  assign cnt_dec    = cnt_q - 1'b1;
  assign q_take_o   = (state_q == StIdle) && q_valid_i;
  assign empty      = !out_valid_q;
  assign digit_o    = out_digit_q;
  assign last_o     = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      work_q      <= '0;
      rem_q       <= '0;
      radix_q     <= RADIX_RESET;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_digit_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
        out_digit_q <= stack_q[cnt_dec[IDX_W-1:0]];
        out_last_q  <= (cnt_q == CNT_W'(1));
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (q_valid_i) begin
            // Hold the radix for the whole item.
            work_q  <= PAD_BITS'(q_value_i);
            rem_q   <= '0;
            radix_q <= radix_i;
            step_q  <= '0;
            cnt_q   <= '0;
            state_q <= StDivide;
          end
        end
        StDivide: begin
          work_q <= div_work;
          if (digit_done) begin
            rem_q  <= '0;
            step_q <= '0;
            cnt_q  <= cnt_q + 1'b1;
            if (div_work == '0) begin
              state_q <= StEmit;
            end
          end else begin
            rem_q  <= div_rem;
            step_q <= step_q + 1'b1;
          end
        end
        StEmit: begin
          if (load_out) begin
            cnt_q <= cnt_dec;
            if (cnt_q == CNT_W'(1)) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (digit_done) begin
      stack_q[cnt_q[IDX_W-1:0]] <= div_rem;
    end
  end

endmodule

### rtl/core/radix_digit_converter_unit.sv
// Top level of the radix digit converter: radix register, front queue and
// divider back end. Depends on rdc_pkg, rdc_front and rdc_back.
//
// Each pushed value is converted to the configured radix (2..36, clamped) and
// popped as a run of digits, most significant first, last_o set on the least
// significant one; a zero value yields no digits. The divider resolves four
// quotient bits per cycle and runs over the whole padded value for each digit;
// the back end takes no new value until every digit of the current one has
// moved into the result register. A two-entry queue in front takes new values
// while a conversion runs, and the result register lets the next value start
// dividing while the last digit of the previous one still waits to be popped.
// Write the radix only while idle.
module radix_digit_converter_unit
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RADIX_W-1:0]    cfg_wdata_i,
  input  logic                  push,
  output logic                  full,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [RADIX_W-1:0]    digit_o,
  output logic                  last_o
);

  logic [RADIX_W-1:0]    radix_q;
  logic                  q_valid;
  logic [VALUE_BITS-1:0] q_value;
  logic                  q_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= sat_radix(cfg_wdata_i);
    end
  end

  rdc_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .value_i  (value_i),
    .q_valid_o(q_valid),
    .q_value_o(q_value),
    .q_take_i (q_take)
  );

  rdc_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .radix_i  (radix_q),
    .q_valid_i(q_valid),
    .q_value_i(q_value),
    .q_take_o (q_take),
    .empty    (empty),
    .pop      (pop),
    .digit_o  (digit_o),
    .last_o   (last_o)
  );

  // A digit is always below the clamped radix, hence below the top radix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (digit_o < RADIX_MAX))
    else $error("digit out of range");

  // Hold a waiting digit until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(digit_o) && $stable(last_o)))
    else $error("waiting digit changed before its transfer");

endmodule

### tb/sv/tb_radix_digit_converter_unit.sv
// Self-checking testbench for radix_digit_converter_unit: pushes values,
// predicts the digit runs for the current radix and checks every popped digit.
// Depends on rdc_pkg and the RTL of the block; needs nothing else.
module tb_radix_digit_converter_unit;
  import rdc_pkg::*;

  localparam int unsigned VBITS          = VALUE_BITS_DEF;
  localparam int          DRAIN_CYCLES   = 400;   // one full radix-2 conversion and margin
  localparam int          WATCHDOG_LIMIT = 4000;  // cycles without any transfer
  localparam int          CHUNK_ITEMS    = 30;

  typedef struct packed {
    logic [RADIX_W-1:0] digit;
    logic               last;
  } digit_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [RADIX_W-1:0] cfg_wdata_i = '0;
  logic               push        = 1'b0;
  logic               full;
  logic [VBITS-1:0]   value_i     = '0;
  logic               empty;
  logic               pop         = 1'b0;
  logic [RADIX_W-1:0] digit_o;
  logic               last_o;

  digit_result_t      pending_digits[$];
  logic [RADIX_W-1:0] radix_shadow  = RADIX_RESET;
  int                 send_idle_pct = 0;
  int                 pop_stall_pct = 0;
  int                 mismatches    = 0;
  int                 values_sent   = 0;
  int                 digits_checked = 0;
  int                 radix_writes  = 0;
  int                 quiet_cycles  = 0;

  radix_digit_converter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .empty       (empty),
    .pop         (pop),
    .digit_o     (digit_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: %s expected %0d got %0d (digit #%0d)", what, want, got,
               digits_checked);
  endtask

  // Expected digit run of one value, most significant digit first.
  function automatic void predict_digits(input logic [VBITS-1:0] v);
    longint unsigned    quot;
    longint unsigned    base;
    logic [RADIX_W-1:0] stack[VBITS];
    int                 depth;
    base = radix_shadow;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    quot  = v;
    depth = 0;
    while (quot != 0 && depth < VBITS) begin
      stack[depth] = RADIX_W'(quot % base);
      depth++;
      quot = quot / base;
    end
    while (depth > 0) begin
      depth--;
      pending_digits.push_back('{digit: stack[depth], last: (depth == 0)});
    end
  endfunction

  // Hold push until the transfer, then idle the sender at random.
  task automatic send_value(input logic [VBITS-1:0] v);
    push    <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (full);
    predict_digits(v);
    values_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  // Drop push, wait for every digit, then wait out the drain interval.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] raw);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= raw;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    radix_shadow = raw;
    radix_writes++;
  endtask

  function automatic logic [VBITS-1:0] random_value();
    logic [VBITS-1:0] v;
    v = VBITS'($urandom);
    if ($urandom_range(0, 99) < 8) return '0;
    if ($urandom_range(0, 99) < 10) return v | VBITS'(1) << (VBITS - 1);
    return v >> $urandom_range(0, VBITS - 1);
  endfunction

  function automatic logic [RADIX_W-1:0] random_radix();
    if ($urandom_range(0, 99) < 80) return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    return RADIX_W'($urandom_range(0, (1 << RADIX_W) - 1));
  endfunction

  task automatic test_reset_radix();
    send_value('0);
    send_value(VBITS'(1));
    send_value(VBITS'(10));
    send_value({VBITS{1'b1}});
    send_value(VBITS'({(VBITS + 1) / 2{2'b01}}));
  endtask

  // Clamped and boundary radix values, each with an all-ones value and a
  // single top digit.
  task automatic test_radix_extremes();
    logic [RADIX_W-1:0] raws[6];
    logic [RADIX_W-1:0] eff;
    raws = '{6'd0, 6'd1, RADIX_MIN, RADIX_MAX, 6'd37, 6'd63};
    foreach (raws[i]) begin
      set_radix(raws[i]);
      eff = raws[i] < RADIX_MIN ? RADIX_MIN : (raws[i] > RADIX_MAX ? RADIX_MAX : raws[i]);
      send_value({VBITS{1'b1}});
      send_value(VBITS'(eff - 1));
    end
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if (i % CHUNK_ITEMS == 0) set_radix(random_radix());
      send_value(random_value());
    end
  endtask

  always @(posedge clk_i) begin : digit_checker
    digit_result_t want;
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || cfg_we_i) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("[radix_digit_converter_unit] ERROR");
        $finish;
      end else if (pop && !empty) begin
        if (pending_digits.size() == 0) begin
          note_mismatch("unexpected digit", -1, digit_o);
        end else begin
          want = pending_digits.pop_front();
          if (digit_o !== want.digit) note_mismatch("digit", want.digit, digit_o);
          if (last_o !== want.last) note_mismatch("last", want.last, last_o);
        end
        digits_checked++;
      end
      pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_radix();
    test_radix_extremes();
    test_random_phase(0, 0, 90);
    test_random_phase(69, 0, 90);
    test_random_phase(0, 69, 90);
    test_random_phase(19, 19, 90);
    wait_idle();
    if (pending_digits.size() != 0) note_mismatch("digits left over", 0,
                                                  pending_digits.size());
    $display("converted %0d values into %0d digits over %0d radix settings",
             values_sent, digits_checked, radix_writes);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[radix_digit_converter_unit] OK");
    end else begin
      $display("[radix_digit_converter_unit] ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/rdc_pkg.sv
rtl/core/rdc_front.sv
rtl/core/rdc_back.sv
rtl/core/radix_digit_converter_unit.sv
tb/sv/tb_radix_digit_converter_unit.sv
